// File: sv/kphc_pkg.sv
// Package: shared types and constants of the key press / hold event classifier.
package kphc_pkg;

    // Width of the key mask and of the hold timer
    localparam int KEY_W = 16;
    localparam int TIMER_W = 16;

    localparam logic [TIMER_W-1:0] HOLD_TIMEOUT_RESET = 16'd2000;

    // Input commands
    localparam logic [1:0] CMD_DOWN = 2'd0;
    localparam logic [1:0] CMD_UP   = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    // Event kinds
    localparam logic [1:0] EV_DOWN  = 2'd0;
    localparam logic [1:0] EV_PRESS = 2'd1;
    localparam logic [1:0] EV_UP    = 2'd2;
    localparam logic [1:0] EV_HOLD  = 2'd3;

    // Chord phase, one-hot
    typedef enum logic [2:0] {
        PH_NONE = 3'b001,
        PH_DOWN = 3'b010,
        PH_SENT = 3'b100
    } phase_t;

    // One input request
    typedef struct packed {
        logic [1:0] command;
        logic [3:0] key_index;
    } cmd_item_t;

    // One result
    typedef struct packed {
        logic [1:0]       event_kind;
        logic [KEY_W-1:0] key_bits;
        logic             last;
    } event_item_t;

    // Queue entry: one event, or a press followed by an up
    typedef struct packed {
        logic             pair;
        logic [1:0]       kind;
        logic [KEY_W-1:0] bits;
        logic [KEY_W-1:0] up_bits;
    } qent_t;

endpackage

// File: sv/kphc_front.sv
// Front end: holds key state and hold timer, classifies each request into at most one queue entry.
module kphc_front #(
    parameter int NUM_KEYS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  kphc_pkg::cmd_item_t           item,
    input  logic                          cfg_we,
    input  logic [kphc_pkg::TIMER_W-1:0]  cfg_data,
    output logic                          enq,
    output kphc_pkg::qent_t               entry
);

    localparam logic [5:0] KeyLimit = 6'(NUM_KEYS);

    logic [kphc_pkg::TIMER_W-1:0] timeout_reg;
    logic [kphc_pkg::KEY_W-1:0]   held_mask_reg, held_mask_next;
    kphc_pkg::phase_t             phase_reg, phase_next;
    logic                         hold_armed_reg, hold_armed_next;
    logic [kphc_pkg::TIMER_W-1:0] hold_count_reg, hold_count_next;
    logic [kphc_pkg::KEY_W-1:0]   hold_chord_reg, hold_chord_next;

    logic [kphc_pkg::KEY_W-1:0]   key_bit;
    logic [kphc_pkg::KEY_W-1:0]   mask_cleared;
    logic                         in_range;
    logic                         is_held;
    kphc_pkg::phase_t             ph_eff;
    logic [kphc_pkg::TIMER_W-1:0] count_inc;
    logic [kphc_pkg::TIMER_W-1:0] limit;

    // Decode of the key and timer helpers
    assign key_bit      = {{(kphc_pkg::KEY_W-1){1'b0}}, 1'b1} << item.key_index;
    assign in_range     = {2'b00, item.key_index} < KeyLimit;
    assign is_held      = |(held_mask_reg & key_bit);
    assign mask_cleared = held_mask_reg & ~key_bit;
    assign count_inc    = hold_count_reg + 1'b1;
    assign limit        = (timeout_reg == '0) ? {{(kphc_pkg::TIMER_W-1){1'b0}}, 1'b1}
                                              : timeout_reg;

    // Phase seen by a new key: empty mask or idle phase starts a chord
    always_comb
    begin
        if (held_mask_reg == '0)
        begin
            ph_eff = kphc_pkg::PH_DOWN;
        end
        else
        begin
            unique case (phase_reg)
                kphc_pkg::PH_NONE: ph_eff = kphc_pkg::PH_DOWN;
                kphc_pkg::PH_DOWN: ph_eff = kphc_pkg::PH_DOWN;
                kphc_pkg::PH_SENT: ph_eff = kphc_pkg::PH_SENT;
                default:           ph_eff = kphc_pkg::PH_NONE;
            endcase
        end
    end

    // Classification and next state
    always_comb
    begin
        held_mask_next  = held_mask_reg;
        phase_next      = phase_reg;
        hold_armed_next = hold_armed_reg;
        hold_count_next = hold_count_reg;
        hold_chord_next = hold_chord_reg;
        enq             = 1'b0;
        entry           = '0;
        if (accept)
        begin
            case (item.command)
                kphc_pkg::CMD_TICK:
                begin
                    if (hold_armed_reg)
                    begin
                        hold_count_next = count_inc;
                        if (count_inc >= limit)
                        begin
                            hold_armed_next = 1'b0;
                            phase_next      = kphc_pkg::PH_SENT;
                            enq             = 1'b1;
                            entry.kind      = kphc_pkg::EV_HOLD;
                            entry.bits      = hold_chord_reg;
                        end
                    end
                end
                kphc_pkg::CMD_DOWN:
                begin
                    if (in_range && !is_held)
                    begin
                        phase_next = ph_eff;
                        if (ph_eff == kphc_pkg::PH_DOWN)
                        begin
                            held_mask_next  = held_mask_reg | key_bit;
                            hold_armed_next = 1'b1;
                            hold_count_next = '0;
                            hold_chord_next = held_mask_reg | key_bit;
                            enq             = 1'b1;
                            entry.kind      = kphc_pkg::EV_DOWN;
                            entry.bits      = key_bit;
                        end
                    end
                end
                kphc_pkg::CMD_UP:
                begin
                    if (in_range && is_held)
                    begin
                        if (phase_reg == kphc_pkg::PH_DOWN)
                        begin
                            enq           = 1'b1;
                            entry.pair    = 1'b1;
                            entry.kind    = kphc_pkg::EV_PRESS;
                            entry.bits    = held_mask_reg;
                            entry.up_bits = key_bit;
                            phase_next    = kphc_pkg::PH_SENT;
                        end
                        else if (phase_reg == kphc_pkg::PH_SENT)
                        begin
                            enq        = 1'b1;
                            entry.kind = kphc_pkg::EV_UP;
                            entry.bits = key_bit;
                        end
                        hold_armed_next = 1'b0;
                        held_mask_next  = mask_cleared;
                        if (mask_cleared == '0)
                        begin
                            phase_next = kphc_pkg::PH_NONE;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= kphc_pkg::HOLD_TIMEOUT_RESET;
            held_mask_reg  <= '0;
            phase_reg      <= kphc_pkg::PH_NONE;
            hold_armed_reg <= 1'b0;
            hold_count_reg <= '0;
            hold_chord_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_data;
            end
            held_mask_reg  <= held_mask_next;
            phase_reg      <= phase_next;
            hold_armed_reg <= hold_armed_next;
            hold_count_reg <= hold_count_next;
            hold_chord_reg <= hold_chord_next;
        end
    end

    // An empty mask always means no chord is in progress
    a_empty_mask_idle: assert property (@(posedge clk) disable iff (!rst_n)
        held_mask_reg == '0 |-> phase_reg == kphc_pkg::PH_NONE)
        else $error("key mask empty while chord phase active");

    // A key_down event always arms the hold timer
    a_down_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (enq && entry.kind == kphc_pkg::EV_DOWN && !entry.pair) |=> hold_armed_reg)
        else $error("key_down without hold timer armed");

endmodule

// File: sv/kphc_queue.sv
// Entry queue between the classifier front end and the result back end.
module kphc_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            enq,
    input  kphc_pkg::qent_t enq_data,
    input  logic            deq,
    output kphc_pkg::qent_t head,
    output logic            q_empty,
    output logic            q_full
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    kphc_pkg::qent_t mem_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign head    = mem_reg[rd_ptr_reg];
    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == FullCnt);

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (enq)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (deq)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (enq && !deq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (deq && !enq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            mem_reg[wr_ptr_reg] <= enq_data;
        end
    end

    // No overflow or underflow of the entry queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(enq && q_full) && !(deq && q_empty))
        else $error("entry queue overflow or underflow");

endmodule

// File: sv/kphc_back.sv
// Back end: expands queue entries into single results held in an output register.
module kphc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  kphc_pkg::qent_t       head,
    input  logic                  q_empty,
    output logic                  deq,
    input  logic                  pop,
    output logic                  empty,
    output kphc_pkg::event_item_t result
);

    logic                        out_valid_reg, out_valid_next;
    kphc_pkg::event_item_t       out_reg, out_next;
    logic                        second_pend_reg, second_pend_next;
    logic [kphc_pkg::KEY_W-1:0]  second_bits_reg, second_bits_next;
    logic                        load_ok;

    assign empty   = !out_valid_reg;
    assign result  = out_reg;
    assign load_ok = !out_valid_reg || pop;
    assign deq     = load_ok && !second_pend_reg && !q_empty;

    // Output register load: pending key_up first, then the queue head
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_next         = out_reg;
        second_pend_next = second_pend_reg;
        second_bits_next = second_bits_reg;
        if (load_ok)
        begin
            if (second_pend_reg)
            begin
                out_valid_next      = 1'b1;
                out_next.event_kind = kphc_pkg::EV_UP;
                out_next.key_bits   = second_bits_reg;
                out_next.last       = 1'b1;
                second_pend_next    = 1'b0;
            end
            else if (!q_empty)
            begin
                out_valid_next      = 1'b1;
                out_next.event_kind = head.kind;
                out_next.key_bits   = head.bits;
                out_next.last       = !head.pair;
                second_pend_next    = head.pair;
                second_bits_next    = head.up_bits;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            second_pend_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg   <= out_valid_next;
            second_pend_reg <= second_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg         <= out_next;
        second_bits_reg <= second_bits_next;
    end

    // A pending key_up only exists behind a press shown on the output
    a_second_behind_press: assert property (@(posedge clk) disable iff (!rst_n)
        second_pend_reg |-> (out_valid_reg && out_reg.event_kind == kphc_pkg::EV_PRESS
                             && !out_reg.last))
        else $error("pending key_up without press on output");

    // A shown result leaves only when taken
    a_hold_until_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && $stable(out_reg)))
        else $error("result dropped or changed before pop");

endmodule

// File: sv/key_press_hold_event_classifier.sv
// Top level of the key press / hold event classifier.
//
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------
//  requests  | push / full            | cmd_item   (command, key_index)
//  results   | pop / empty            | event_item (event_kind, key_bits, last)
//  config    | cfg_valid / cfg_ready  | cfg_data   (hold_timeout_ticks)
//
// One request is taken every cycle while full is low; its results pass through a
// queue entry and then the output register.
// A release during the down phase yields two results on consecutive pops.
// full rises when QUEUE_DEPTH entries wait behind a stalled result consumer.
// Reset clears the key mask, phase and hold timer; the timeout returns to 2000.
// cfg_ready is always high; writes are meant to happen while the block is idle.
module key_press_hold_event_classifier #(
    parameter int NUM_KEYS    = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  kphc_pkg::cmd_item_t           cmd_item,
    output logic                          empty,
    input  logic                          pop,
    output kphc_pkg::event_item_t         event_item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kphc_pkg::TIMER_W-1:0]  cfg_data
);

    logic            accept;
    logic            enq;
    logic            deq;
    logic            q_empty;
    logic            q_full;
    kphc_pkg::qent_t enq_data;
    kphc_pkg::qent_t head;

    assign full      = q_full;
    assign accept    = push && !q_full;
    assign cfg_ready = 1'b1;

    kphc_front #(
        .NUM_KEYS (NUM_KEYS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (cmd_item),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .enq      (enq),
        .entry    (enq_data)
    );

    kphc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .enq      (enq),
        .enq_data (enq_data),
        .deq      (deq),
        .head     (head),
        .q_empty  (q_empty),
        .q_full   (q_full)
    );

    kphc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .deq     (deq),
        .pop     (pop),
        .empty   (empty),
        .result  (event_item)
    );

endmodule

// File: tb/key_press_hold_event_classifier_test.sv
// Self-checking testbench for the key press / hold event classifier.
module key_press_hold_event_classifier_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Command code outside the defined set, must be ignored
    localparam logic [1:0] CmdUnused = 2'd3;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          push;
    logic                          full;
    kphc_pkg::cmd_item_t           cmd_item;
    logic                          empty;
    logic                          pop;
    kphc_pkg::event_item_t         event_item;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [kphc_pkg::TIMER_W-1:0]  cfg_data;

    key_press_hold_event_classifier i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd_item   (cmd_item),
        .empty      (empty),
        .pop        (pop),
        .event_item (event_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Mirror of the classifier state
    logic [kphc_pkg::KEY_W-1:0]   held_keys;
    kphc_pkg::phase_t             chord_phase;
    logic                         timer_armed;
    logic [kphc_pkg::TIMER_W-1:0] timer_count;
    logic [kphc_pkg::KEY_W-1:0]   timer_chord;
    logic [kphc_pkg::TIMER_W-1:0] timeout_ticks;

    kphc_pkg::event_item_t        pending_events[$];
    int                           mismatches;
    int                           requests_sent;
    int                           send_idle_pct;
    int                           recv_idle_pct;

    // One line per mismatch
    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
        mismatches++;
    endtask

    // Work out the events caused by one accepted request
    task automatic predict_events(input kphc_pkg::cmd_item_t req);
        kphc_pkg::event_item_t        batch[$];
        kphc_pkg::event_item_t        ev;
        logic [kphc_pkg::KEY_W-1:0]   key_bit;
        logic [kphc_pkg::TIMER_W-1:0] limit;
        key_bit = {{(kphc_pkg::KEY_W-1){1'b0}}, 1'b1} << req.key_index;
        ev = '0;
        case (req.command)
            kphc_pkg::CMD_TICK:
            begin
                if (timer_armed)
                begin
                    limit = (timeout_ticks == '0) ? 16'd1 : timeout_ticks;
                    timer_count = timer_count + 1'b1;
                    if (timer_count >= limit)
                    begin
                        timer_armed = 1'b0;
                        chord_phase = kphc_pkg::PH_SENT;
                        ev.event_kind = kphc_pkg::EV_HOLD;
                        ev.key_bits = timer_chord;
                        batch.push_back(ev);
                    end
                end
            end
            kphc_pkg::CMD_DOWN:
            begin
                if ((held_keys & key_bit) == '0)
                begin
                    if (held_keys == '0)
                        chord_phase = kphc_pkg::PH_NONE;
                    if (chord_phase == kphc_pkg::PH_NONE)
                        chord_phase = kphc_pkg::PH_DOWN;
                    // a new key after a press or hold is dropped
                    if (chord_phase == kphc_pkg::PH_DOWN)
                    begin
                        held_keys = held_keys | key_bit;
                        ev.event_kind = kphc_pkg::EV_DOWN;
                        ev.key_bits = key_bit;
                        batch.push_back(ev);
                        timer_armed = 1'b1;
                        timer_count = '0;
                        timer_chord = held_keys;
                    end
                end
            end
            kphc_pkg::CMD_UP:
            begin
                if ((held_keys & key_bit) != '0)
                begin
                    if (chord_phase == kphc_pkg::PH_DOWN)
                    begin
                        ev.event_kind = kphc_pkg::EV_PRESS;
                        ev.key_bits = held_keys;
                        batch.push_back(ev);
                        ev.event_kind = kphc_pkg::EV_UP;
                        ev.key_bits = key_bit;
                        batch.push_back(ev);
                        chord_phase = kphc_pkg::PH_SENT;
                    end
                    else if (chord_phase == kphc_pkg::PH_SENT)
                    begin
                        ev.event_kind = kphc_pkg::EV_UP;
                        ev.key_bits = key_bit;
                        batch.push_back(ev);
                    end
                    timer_armed = 1'b0;
                    held_keys = held_keys & ~key_bit;
                    if (held_keys == '0)
                        chord_phase = kphc_pkg::PH_NONE;
                end
            end
            default: ;
        endcase
        foreach (batch[i])
        begin
            ev = batch[i];
            ev.last = (i == batch.size() - 1);
            pending_events.push_back(ev);
        end
    endtask

    // Send one request, idling at random first, and predict its events
    task automatic send_request(input logic [1:0] command, input logic [3:0] key);
        kphc_pkg::cmd_item_t req;
        req.command = command;
        req.key_index = key;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        cmd_item <= req;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_events(req);
        requests_sent++;
    endtask

    task automatic send_ticks(input int count);
        repeat (count)
            send_request(kphc_pkg::CMD_TICK, 4'($urandom_range(15)));
    endtask

    // Stop sending and wait until every expected event has come out
    task automatic wait_until_idle();
        push <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
    endtask

    task automatic write_timeout(input logic [kphc_pkg::TIMER_W-1:0] value);
        wait_until_idle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        timeout_ticks = value;
    endtask

    // Result side: random stalls on pop
    always @(posedge clk)
        pop <= ($urandom_range(99) >= recv_idle_pct);

    // Compare each popped event with the oldest expectation
    always @(posedge clk)
    begin : check_events
        kphc_pkg::event_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_events.size() == 0)
            begin
                report_mismatch("unexpected event", 0, int'(event_item.key_bits));
            end
            else
            begin
                want = pending_events.pop_front();
                if (event_item.event_kind != want.event_kind)
                    report_mismatch("event_kind", int'(want.event_kind),
                                    int'(event_item.event_kind));
                if (event_item.key_bits != want.key_bits)
                    report_mismatch("key_bits", int'(want.key_bits),
                                    int'(event_item.key_bits));
                if (event_item.last != want.last)
                    report_mismatch("last", int'(want.last), int'(event_item.last));
            end
        end
    end

    // Reset timeout is long: a short chord gives no hold
    task automatic test_hold_at_reset_timeout();
        send_request(kphc_pkg::CMD_DOWN, 4'd5);
        send_ticks(40);
        send_request(kphc_pkg::CMD_UP, 4'd5);
        send_request(kphc_pkg::CMD_DOWN, 4'd6);
        send_ticks(40);
        send_request(kphc_pkg::CMD_UP, 4'd6);
    endtask

    // Repeated down, stray up, down after a press, unknown command, hold, zero timeout
    task automatic test_special_cases();
        write_timeout(16'd2);
        send_request(kphc_pkg::CMD_DOWN, 4'd0);
        send_request(kphc_pkg::CMD_DOWN, 4'd0);
        send_request(kphc_pkg::CMD_DOWN, 4'd15);
        send_ticks(1);
        send_request(kphc_pkg::CMD_UP, 4'd15);
        send_request(kphc_pkg::CMD_DOWN, 4'd7);
        send_request(kphc_pkg::CMD_UP, 4'd7);
        send_request(kphc_pkg::CMD_UP, 4'd0);
        send_request(kphc_pkg::CMD_UP, 4'd3);
        send_request(CmdUnused, 4'd9);
        send_request(CmdUnused, 4'd6);
        send_request(kphc_pkg::CMD_DOWN, 4'd9);
        send_ticks(3);
        send_request(kphc_pkg::CMD_UP, 4'd9);
        write_timeout(16'd0);
        send_request(kphc_pkg::CMD_DOWN, 4'd1);
        send_request(kphc_pkg::CMD_DOWN, 4'd10);
        send_ticks(2);
        send_request(kphc_pkg::CMD_UP, 4'd10);
        send_request(kphc_pkg::CMD_UP, 4'd1);
        write_timeout(16'd1);
        send_request(kphc_pkg::CMD_DOWN, 4'd12);
        send_ticks(1);
        send_request(kphc_pkg::CMD_UP, 4'd12);
    endtask

    // Largest timeout: a short chord never reaches the hold
    task automatic test_max_timeout();
        write_timeout(16'hFFFF);
        send_request(kphc_pkg::CMD_DOWN, 4'd15);
        send_request(kphc_pkg::CMD_DOWN, 4'd0);
        send_ticks(40);
        send_request(kphc_pkg::CMD_UP, 4'd0);
        send_request(kphc_pkg::CMD_UP, 4'd15);
    endtask

    // One well-formed chord: keys go down, ticks pass, keys come up
    task automatic random_chord();
        logic [3:0] keys[$];
        int         n_keys;
        int         pick;
        logic [3:0] key;
        n_keys = $urandom_range(4, 1);
        repeat (n_keys)
        begin
            key = 4'($urandom_range(15));
            keys.push_back(key);
            send_request(kphc_pkg::CMD_DOWN, key);
            send_ticks($urandom_range(3));
        end
        if ($urandom_range(3) == 0)
            send_request(kphc_pkg::CMD_DOWN, 4'($urandom_range(15)));
        while (keys.size() != 0)
        begin
            pick = $urandom_range(keys.size() - 1);
            send_request(kphc_pkg::CMD_UP, keys[pick]);
            keys.delete(pick);
            send_ticks($urandom_range(2));
        end
    endtask

    // Chords with random content, some noise, new timeout every chunk
    task automatic run_random_chunks(input int chunks);
        int stop_at;
        repeat (chunks)
        begin
            write_timeout(16'($urandom_range(6)));
            stop_at = requests_sent + 90;
            while (requests_sent < stop_at)
            begin
                if ($urandom_range(99) < 80)
                    random_chord();
                else
                    send_request(2'($urandom_range(3)), 4'($urandom_range(15)));
            end
        end
    endtask

    task automatic test_random_traffic();
        send_idle_pct = 34;
        recv_idle_pct = 52;
        run_random_chunks(5);
        wait_until_idle();
        send_idle_pct = 52;
        recv_idle_pct = 34;
        run_random_chunks(5);
        wait_until_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_chunks(5);
    endtask

    // Watchdog
    initial
    begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        cmd_item = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        pop = 1'b0;
        mismatches = 0;
        requests_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        held_keys = '0;
        chord_phase = kphc_pkg::PH_NONE;
        timer_armed = 1'b0;
        timer_count = '0;
        timer_chord = '0;
        timeout_ticks = kphc_pkg::HOLD_TIMEOUT_RESET;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_hold_at_reset_timeout();
        test_special_cases();
        test_max_timeout();
        test_random_traffic();

        wait_until_idle();
        repeat (20)
            @(posedge clk);
        if (mismatches == 0 && pending_events.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
